/* src/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants of the UTF-8 stream decoder
// Holds the field widths, byte classification constants and the structs
// that pass between the decoder stage and the output sequencer.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CP_W   = 21;
	localparam int BYTE_W = 8;
	localparam int BC_W   = 3;
	localparam int OUT_W  = CP_W + BC_W;

	localparam logic [CP_W-1:0] REPL_RESET = 21'd65533;

	// Byte classification
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] LEAD_MASK  = 8'hF8;
	localparam logic [7:0] PAY2_MASK  = 8'h1F;
	localparam logic [7:0] PAY3_MASK  = 8'h0F;
	localparam logic [7:0] PAY4_MASK  = 8'h07;
	localparam logic [7:0] CONT_PAY   = 8'h3F;

	// Sequence lengths
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// Open sequence held between bytes
	typedef struct packed {
		logic [2:0]      exp_len;
		logic [1:0]      held;
		logic [CP_W-1:0] partial;
	} seq_t;

	// Results caused by one byte: a run of replacements, then an optional value
	typedef struct packed {
		logic [2:0]      rep_cnt;
		logic            has_val;
		logic [CP_W-1:0] val_cp;
		logic [BC_W-1:0] val_bc;
	} burst_t;

endpackage

/* src/utf8_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core: lenient UTF-8 byte stream decoder
// Turns a stream of text bytes into code points, with a programmable
// replacement value for bytes that cannot be decoded.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  ---------------------------------------------------
//  s_*      in         tdata[7:0] text byte, tlast end of text
//  m_*      out        tdata[20:0] code point, tdata[23:21] byte count,
//                      tlast final result of the source byte
//  cfg_*    in         cfg_data[20:0] replacement value (always ready)
//
//  A byte passes an input register and the decode logic into the result
//  register, from which its results are offered on m_*. With the output
//  always ready one byte is taken every cycle, unless a byte gives
//  several results; such a byte holds the result register until its last
//  result is taken, which stalls input.
//  Reset clears the open sequence and loads the replacement value 0xFFFD.
//  Output stalls back up through the result register to s_tready.
//
module utf8_stream_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// input bytes
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] text_byte
	input  logic                          s_tlast,   // end_of_text
	// decoded code points
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [utf8d_pkg::OUT_W-1:0]   m_tdata,   // [20:0] code_point, [23:21] byte_count
	output logic                          m_tlast,   // run_last
	// replacement value register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [utf8d_pkg::CP_W-1:0]    cfg_data
);

	// Input register stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;

	logic [utf8d_pkg::CP_W-1:0] repl_q;

	utf8d_pkg::burst_t burst;
	logic              load_ok;
	logic              advance;

	// The byte in the input register moves on once the result register can
	// take its results; a new byte may enter in that same cycle.
	assign advance   = valid_s1 && load_ok;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	// The user must rewrite the replacement value only while the block is idle, so
	// the output side may read it live; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= utf8d_pkg::REPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repl_q <= cfg_data;
		end
	end

	utf8d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.eot_in  (eot_s1),
		.burst   (burst)
	);

	utf8d_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.burst    (burst),
		.repl     (repl_q),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* src/utf8d_decode.sv */
// ----------------------------------------------------------------------------
// utf8d_decode: per-byte decode logic and sequence state
// Works out the results of one byte against the open sequence and keeps
// the sequence state, which advances when the byte moves on.
// ----------------------------------------------------------------------------
module utf8d_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          byte_in,
	input  logic                eot_in,
	output utf8d_pkg::burst_t   burst
);

	utf8d_pkg::seq_t seq_q;
	utf8d_pkg::seq_t seq_next;

	logic                        is_cont;
	logic                        breaking;
	logic [2:0]                  pre_rep;
	logic [2:0]                  held_inc;
	logic [utf8d_pkg::CP_W-1:0]  pv_inc;
	logic [2:0]                  lead_len;
	logic [utf8d_pkg::CP_W-1:0]  lead_val;

	always_comb begin
		is_cont  = (byte_in & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_CODE;
		breaking = (seq_q.exp_len != utf8d_pkg::LEN_NONE) && !is_cont;
		pre_rep  = breaking ? (3'd1 + {1'b0, seq_q.held}) : 3'd0;
		held_inc = {1'b0, seq_q.held} + 3'd1;
		pv_inc   = {seq_q.partial[utf8d_pkg::CP_W-7:0], byte_in[5:0]};

		case (byte_in & utf8d_pkg::LEAD_MASK)
			8'hC0, 8'hC8, 8'hD0, 8'hD8: begin
				lead_len = utf8d_pkg::LEN_TWO;
				lead_val = {13'd0, byte_in & utf8d_pkg::PAY2_MASK};
			end
			8'hE0, 8'hE8: begin
				lead_len = utf8d_pkg::LEN_THREE;
				lead_val = {13'd0, byte_in & utf8d_pkg::PAY3_MASK};
			end
			8'hF0: begin
				lead_len = utf8d_pkg::LEN_FOUR;
				lead_val = {13'd0, byte_in & utf8d_pkg::PAY4_MASK};
			end
			default: begin
				lead_len = utf8d_pkg::LEN_NONE;
				lead_val = '0;
			end
		endcase

		burst    = '0;
		seq_next = '0;

		if (seq_q.exp_len != utf8d_pkg::LEN_NONE && is_cont) begin
			if ((held_inc + 3'd1) >= seq_q.exp_len) begin
				burst.has_val = 1'b1;
				burst.val_cp  = pv_inc;
				burst.val_bc  = seq_q.exp_len;
			end else if (eot_in) begin
				burst.rep_cnt = held_inc + 3'd1;
			end else begin
				seq_next.exp_len = seq_q.exp_len;
				seq_next.held    = held_inc[1:0];
				seq_next.partial = pv_inc;
			end
		end else begin
			// No sequence open, or the open one has just been broken and flushed
			if (byte_in[7] == 1'b0) begin
				burst.rep_cnt = pre_rep;
				burst.has_val = 1'b1;
				burst.val_cp  = {13'd0, byte_in};
				burst.val_bc  = utf8d_pkg::LEN_ONE;
			end else if (lead_len != utf8d_pkg::LEN_NONE && !eot_in) begin
				burst.rep_cnt    = pre_rep;
				seq_next.exp_len = lead_len;
				seq_next.partial = lead_val;
			end else begin
				// Stray byte, or a lead cut off by the end of the text
				burst.rep_cnt = pre_rep + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (advance) begin
			seq_q <= seq_next;
		end
	end

endmodule

/* src/utf8d_out.sv */
// ----------------------------------------------------------------------------
// utf8d_out: result register and beat sequencer
// Holds the results of one byte and hands them out one beat at a time,
// replacements first, then the decoded value.
// ----------------------------------------------------------------------------
module utf8d_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  utf8d_pkg::burst_t              burst,
	input  logic [utf8d_pkg::CP_W-1:0]     repl,
	output logic                           load_ok,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [utf8d_pkg::OUT_W-1:0]    m_tdata,
	output logic                           m_tlast
);

	logic                 valid_s2;
	utf8d_pkg::burst_t    burst_s2;
	logic                 take;
	logic                 beat_last;
	logic                 nonempty;

	always_comb begin
		take      = valid_s2 && m_tready;
		beat_last = (burst_s2.rep_cnt == 3'd0) ||
			(burst_s2.rep_cnt == 3'd1 && !burst_s2.has_val);
		load_ok   = !valid_s2 || (take && beat_last);
		nonempty  = (burst.rep_cnt != 3'd0) || burst.has_val;

		m_tvalid = valid_s2;
		m_tlast  = beat_last;
		if (burst_s2.rep_cnt != 3'd0) begin
			m_tdata = {utf8d_pkg::LEN_ONE, repl};
		end else begin
			m_tdata = {burst_s2.val_bc, burst_s2.val_cp};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			burst_s2 <= '0;
		end else if (load_ok) begin
			valid_s2 <= load && nonempty;
			if (load) begin
				burst_s2 <= burst;
			end
		end else if (take) begin
			burst_s2.rep_cnt <= burst_s2.rep_cnt - 3'd1;
		end
	end

endmodule

/* src/utf8d_checker.sv */
// ----------------------------------------------------------------------------
// utf8d_checker: port-level checks on the UTF-8 stream decoder
// Watches the result channel and the handshakes of the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [utf8d_pkg::OUT_W-1:0]   m_tdata,
	input  logic                          m_tlast,
	input  logic                          cfg_ready
);

	// A stalled result beat stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat withdrawn while stalled");

	// Every beat accounts for one to four source bytes.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:21] != 3'd0 && m_tdata[23:21] != 3'd5 &&
			m_tdata[23:21] != 3'd6 && m_tdata[23:21] != 3'd7))
		else $error("byte count out of range");

	// Only the final result of a byte can be a multi-byte decode.
	a_inner_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[23:21] == 3'd1)
		else $error("multi-byte result before the end of a run");

	// A beat that is not the last of its run is followed by another beat.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("run broken off before its last beat");

	// The configuration channel never blocks.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_ready (cfg_ready)
);

/* tb/sv/utf8_decoder_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_checker: code point prediction and comparison
// Watches the byte, code point and replacement register channels, decodes
// every accepted byte in step with the design and compares each result beat
// with the oldest code point still owed.
// ----------------------------------------------------------------------------
module utf8_decoder_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [7:0]                  s_tdata,
	input  logic                        s_tlast,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [utf8d_pkg::OUT_W-1:0] m_tdata,
	input  logic                        m_tlast,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [utf8d_pkg::CP_W-1:0]  cfg_data,
	output int                          fail_count,
	output int                          pending,
	output int                          results_seen
);

	localparam int CP_W  = utf8d_pkg::CP_W;
	localparam int BC_W  = utf8d_pkg::BC_W;
	localparam int OUT_W = utf8d_pkg::OUT_W;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [BC_W-1:0] bc;
		logic            last;
	} cp_result_t;

	cp_result_t      cp_owed[$];
	cp_result_t      burst[4];
	int              burst_n;
	cp_result_t      oldest;

	logic [CP_W-1:0] repl_value;
	logic [2:0]      seq_len;
	logic [1:0]      seq_held;
	logic [CP_W-1:0] seq_acc;

	task automatic push_cp(input logic [CP_W-1:0] cp, input logic [BC_W-1:0] bc);
		burst[burst_n] = '{cp, bc, 1'b0};
		burst_n++;
	endtask

	// The lead and every continuation held so far each turn into a replacement.
	task automatic abandon_sequence();
		push_cp(repl_value, utf8d_pkg::LEN_ONE);
		for (int i = 0; i < seq_held; i++)
			push_cp(repl_value, utf8d_pkg::LEN_ONE);
		seq_len  = utf8d_pkg::LEN_NONE;
		seq_held = '0;
		seq_acc  = '0;
	endtask

	task automatic decode_fresh(input logic [7:0] b, input logic eot);
		if (!b[7]) begin
			push_cp(CP_W'(b), utf8d_pkg::LEN_ONE);
		end else if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_CODE ||
				(b & utf8d_pkg::LEAD_MASK) == utf8d_pkg::LEAD_MASK) begin
			push_cp(repl_value, utf8d_pkg::LEN_ONE);
		end else begin
			if (!b[5]) begin
				seq_len = utf8d_pkg::LEN_TWO;
				seq_acc = CP_W'(b & utf8d_pkg::PAY2_MASK);
			end else if (!b[4]) begin
				seq_len = utf8d_pkg::LEN_THREE;
				seq_acc = CP_W'(b & utf8d_pkg::PAY3_MASK);
			end else begin
				seq_len = utf8d_pkg::LEN_FOUR;
				seq_acc = CP_W'(b & utf8d_pkg::PAY4_MASK);
			end
			seq_held = '0;
			if (eot)
				abandon_sequence();
		end
	endtask

	task automatic predict_code_points(input logic [7:0] b, input logic eot);
		burst_n = 0;
		if (seq_len == utf8d_pkg::LEN_NONE) begin
			decode_fresh(b, eot);
		end else if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_CODE) begin
			seq_acc = {seq_acc[CP_W-7:0], b[5:0]};
			if (3'(seq_held) + 3'd2 >= seq_len) begin
				push_cp(seq_acc, seq_len);
				seq_len  = utf8d_pkg::LEN_NONE;
				seq_held = '0;
				seq_acc  = '0;
			end else begin
				seq_held++;
				if (eot)
					abandon_sequence();
			end
		end else begin
			abandon_sequence();
			decode_fresh(b, eot);
		end
		if (burst_n > 0)
			burst[burst_n-1].last = 1'b1;
		for (int i = 0; i < burst_n; i++)
			cp_owed.push_back(burst[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_owed.delete();
			repl_value = utf8d_pkg::REPL_RESET;
			seq_len    = utf8d_pkg::LEN_NONE;
			seq_held   = '0;
			seq_acc    = '0;
		end else begin
			if (cfg_valid && cfg_ready)
				repl_value = cfg_data;
			if (s_tvalid && s_tready)
				predict_code_points(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (cp_owed.size() == 0) begin
					$error("unexpected beat: code_point 0x%06h, byte_count %0d, run_last %0b",
						m_tdata[CP_W-1:0], m_tdata[OUT_W-1:CP_W], m_tlast);
					fail_count++;
				end else begin
					oldest = cp_owed.pop_front();
					if (m_tdata[CP_W-1:0] !== oldest.cp) begin
						$error("code_point: expected 0x%06h, got 0x%06h",
							oldest.cp, m_tdata[CP_W-1:0]);
						fail_count++;
					end
					if (m_tdata[OUT_W-1:CP_W] !== oldest.bc) begin
						$error("byte_count: expected %0d, got %0d",
							oldest.bc, m_tdata[OUT_W-1:CP_W]);
						fail_count++;
					end
					if (m_tlast !== oldest.last) begin
						$error("run_last: expected %0b, got %0b", oldest.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
		pending = cp_owed.size();
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the UTF-8 stream decoder
// Feeds hand-picked byte sequences and then random, mostly well-formed text
// with broken and truncated sequences mixed in, under four replacement
// values and random gaps on both streams. A separate checker predicts and
// compares every code point beat.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CP_W  = utf8d_pkg::CP_W;
	localparam int OUT_W = utf8d_pkg::OUT_W;

	// Cycles without any accepted beat before the run is declared hung. The
	// slowest correct beat waits out a short random stall on the output, so
	// this is very generous.
	localparam int STALL_LIMIT = 2000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = '0;
	logic             s_tlast   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CP_W-1:0]  cfg_data  = '0;

	// When set, both streams idle at random; cleared for one long clean stretch.
	logic             idle_on   = 1'b1;
	int               bytes_sent;
	int               fail_count;
	int               pending;
	int               results_seen;

	always #4 clk = ~clk;

	utf8_stream_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	utf8_decoder_checker decode_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// The receiving side refuses roughly 18 beats in a hundred while idling
	// is enabled, so stalls can land on any beat of a multi-result burst.
	always @(posedge clk) begin
		m_tready <= idle_on ? ($urandom_range(99) >= 18) : 1'b1;
	end

	// Presents one text byte and holds it until the decoder takes it. A short
	// random gap may come first, long enough on average for the sender to
	// idle about 18 percent of the time. The valid line is only ever
	// assigned once per edge: either lowered for a gap or raised for the beat.
	task automatic send_byte(input logic [7:0] b, input logic eot);
		if (idle_on && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 18);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eot;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Stops sending and waits until every code point owed has arrived. The
	// status is read at the falling edge, clear of the checker's update. It
	// then waits on, since a lead byte still in the pipeline owes nothing
	// yet but may still be changing the decoder's state.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The replacement value only changes while the decoder is quiet.
	task automatic write_replacement(input logic [CP_W-1:0] value);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One random character: usually a well-formed sequence of one to four
	// bytes with random payload, sometimes cut short (so the next character
	// breaks it, or end of text lands inside it), sometimes a raw noise byte.
	task automatic send_random_char();
		logic [7:0] lead;
		int         len;
		int         cut;
		logic       eot;
		if ($urandom_range(7) == 0) begin
			send_byte(8'($urandom), $urandom_range(7) == 0);
			return;
		end
		len = $urandom_range(4, 1);
		case (len)
			1: lead = {1'b0, 7'($urandom)};
			2: lead = {3'b110, 5'($urandom)};
			3: lead = {4'b1110, 4'($urandom)};
			default: lead = {5'b11110, 3'($urandom)};
		endcase
		cut = ($urandom_range(7) == 0) ? $urandom_range(len, 1) : len;
		eot = ($urandom_range(9) == 0);
		for (int i = 0; i < cut; i++)
			send_byte((i == 0) ? lead : {2'b10, 6'($urandom)}, eot && (i == cut - 1));
	endtask

	task automatic send_random_text(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at)
			send_random_char();
	endtask

	// Watchdog: ends the run if no beat of any kind is accepted for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the replacement value left at its reset value.
		// ASCII extremes.
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		// Well-formed sequences of two, three and four bytes.
		send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
		send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		// Overlong two-byte form of zero, accepted as it stands.
		send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
		// Stray continuation, and two of the bytes that can never start a sequence.
		send_byte(8'h80, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'hFF, 1'b0);
		// Broken sequence: lead and one continuation, then a plain letter.
		send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b0);
		// Broken by a new lead, which then completes normally.
		send_byte(8'hF0, 1'b0); send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
		// Early end after one continuation of a four-byte sequence.
		send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b1);
		// A lead that is itself the last byte, then end of text on a whole one.
		send_byte(8'hC3, 1'b1);
		send_byte(8'h41, 1'b1);

		// Random text under three more replacement values: all ones, with
		// idling; zero, as one long stretch with idling switched off; then a
		// random value, with idling again.
		write_replacement({CP_W{1'b1}});
		send_random_text(35);

		write_replacement('0);
		idle_on <= 1'b0;
		send_random_text(30);

		write_replacement(CP_W'($urandom));
		idle_on <= 1'b1;
		send_random_text(40);

		wait_for_results();
		repeat (4) @(posedge clk);

		$display("Run covered %0d text bytes and %0d checked code points under four",
			bytes_sent, results_seen);
		$display("replacement values, with broken, truncated and stray bytes and back-pressure.");
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
